[design/sip_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared constants for the front part (classification), the queue and
// the back part (division and point).
// ----------------------------------------------------------------------------
package sip_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_BITS       = 32;
    localparam int QUEUE_DEPTH    = 4;

endpackage
`default_nettype wire
// ----------------------------------------------------------------------------

[design/sip_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection front part
// Forms the four orientation cross products, classifies the pair, and
// registers the numerator, denominator and segment data for the back part.
// Two pipeline stages: differences, then products and classification.
// ----------------------------------------------------------------------------
module sip_front #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
    parameter int PW         = 2 * COORD_BITS + 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic signed [COORD_BITS-1:0] i_ax,
    input  wire logic signed [COORD_BITS-1:0] i_ay,
    input  wire logic signed [COORD_BITS-1:0] i_bx,
    input  wire logic signed [COORD_BITS-1:0] i_by,
    input  wire logic signed [COORD_BITS-1:0] i_cx,
    input  wire logic signed [COORD_BITS-1:0] i_cy,
    input  wire logic signed [COORD_BITS-1:0] i_dx,
    input  wire logic signed [COORD_BITS-1:0] i_dy,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic signed [PW-1:0]              o_num,
    output logic signed [PW-1:0]              o_den,
    output logic signed [COORD_BITS-1:0]      o_ax,
    output logic signed [COORD_BITS-1:0]      o_ay,
    output logic signed [COORD_BITS:0]        o_wx,
    output logic signed [COORD_BITS:0]        o_wy
);
    localparam int DW = COORD_BITS + 1;

    // Stage one: coordinate differences.
    logic              r_v1;
    logic signed [DW-1:0] r_vx, r_vy, r_wx, r_wy;  // v = D-C, w = A-B
    logic signed [DW-1:0] r_acx, r_acy, r_bcx, r_bcy; // A-C, B-C
    logic signed [DW-1:0] r_cax, r_cay, r_dax, r_day; // C-A, D-A
    logic signed [DW-1:0] r_bax, r_bay;               // B-A
    logic signed [COORD_BITS-1:0] r_ax1, r_ay1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_vx  <= DW'(i_dx) - DW'(i_cx);
        r_vy  <= DW'(i_dy) - DW'(i_cy);
        r_wx  <= DW'(i_ax) - DW'(i_bx);
        r_wy  <= DW'(i_ay) - DW'(i_by);
        r_acx <= DW'(i_ax) - DW'(i_cx);
        r_acy <= DW'(i_ay) - DW'(i_cy);
        r_bcx <= DW'(i_bx) - DW'(i_cx);
        r_bcy <= DW'(i_by) - DW'(i_cy);
        r_cax <= DW'(i_cx) - DW'(i_ax);
        r_cay <= DW'(i_cy) - DW'(i_ay);
        r_dax <= DW'(i_dx) - DW'(i_ax);
        r_day <= DW'(i_dy) - DW'(i_ay);
        r_bax <= DW'(i_bx) - DW'(i_ax);
        r_bay <= DW'(i_by) - DW'(i_ay);
        r_ax1 <= i_ax;
        r_ay1 <= i_ay;
    end

    // Stage two: cross products, signs and the hit decision.
    logic signed [PW-1:0] n_s1, n_s2, n_s3, n_s4, n_num, n_den;
    logic                 n_hit;

    always_comb begin
        n_s1  = PW'(r_vx) * PW'(r_acy) - PW'(r_vy) * PW'(r_acx);
        n_s2  = PW'(r_vx) * PW'(r_bcy) - PW'(r_vy) * PW'(r_bcx);
        n_s3  = PW'(r_bax) * PW'(r_cay) - PW'(r_bay) * PW'(r_cax);
        n_s4  = PW'(r_bax) * PW'(r_day) - PW'(r_bay) * PW'(r_dax);
        // Num = (C-A).y-comp form: (cx-ax)*vy + (ay-cy)*vx.
        n_num = PW'(r_cax) * PW'(r_vy) - PW'(r_cay) * PW'(r_vx);
        n_den = PW'(r_vx) * PW'(r_wy) - PW'(r_vy) * PW'(r_wx);
        // Same strict side for both ends of either segment means no hit.
        n_hit = !(((n_s1 > 0) && (n_s2 > 0)) || ((n_s1 < 0) && (n_s2 < 0)) ||
                  ((n_s3 > 0) && (n_s4 > 0)) || ((n_s3 < 0) && (n_s4 < 0)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v1;
        end
        o_hit <= n_hit;
        o_num <= n_num;
        o_den <= n_den;
        o_ax  <= r_ax1;
        o_ay  <= r_ay1;
        o_wx  <= r_wx;
        o_wy  <= r_wy;
    end

endmodule
`default_nettype wire
// ----------------------------------------------------------------------------

[design/sip_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection queue
// Short FIFO between the front and back parts. The back part drains one
// entry per cycle, so it never fills under the command interface.
// ----------------------------------------------------------------------------
module sip_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sip_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    // Pointer and fill count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop && !o_empty);
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

endmodule
`default_nettype wire
// ----------------------------------------------------------------------------

[design/sip_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection back part
// Pipelined restoring divider for alpha (one quotient bit per stage),
// then the point A - alpha*(A-B) over two stages.
// ----------------------------------------------------------------------------
module sip_back #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF,
    parameter int PW         = 2 * COORD_BITS + 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         i_hit,
    input  wire logic signed [PW-1:0]         i_num,
    input  wire logic signed [PW-1:0]         i_den,
    input  wire logic signed [COORD_BITS-1:0] i_ax,
    input  wire logic signed [COORD_BITS-1:0] i_ay,
    input  wire logic signed [COORD_BITS:0]   i_wx,
    input  wire logic signed [COORD_BITS:0]   i_wy,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic                              o_parallel,
    output logic signed [sip_pkg::OUT_BITS-1:0] o_px,
    output logic signed [sip_pkg::OUT_BITS-1:0] o_py
);
    localparam int NS = FRAC_BITS + 1;          // integer step plus fraction steps
    localparam int MW = PW + 1;                 // magnitude / remainder width
    localparam int QW = FRAC_BITS + 2;          // alpha magnitude up to 1.0
    localparam int AW = QW + 1;                 // signed alpha
    localparam int XW = AW + COORD_BITS + 2;    // product width
    localparam int RW = COORD_BITS + FRAC_BITS + 3;
    localparam int FW = (XW > RW) ? XW + 1 : RW + 1;

    // Per-stage pipeline registers.
    logic          r_v   [NS+1];
    logic          r_hit [NS+1];
    logic          r_par [NS+1];
    logic          r_neg [NS+1];
    logic          r_one [NS+1];
    logic [MW-1:0] r_rem [NS+1];
    logic [MW-1:0] r_d   [NS+1];
    logic [QW-1:0] r_q   [NS+1];
    logic signed [COORD_BITS-1:0] r_ax [NS+1];
    logic signed [COORD_BITS-1:0] r_ay [NS+1];
    logic signed [COORD_BITS:0]   r_wx [NS+1];
    logic signed [COORD_BITS:0]   r_wy [NS+1];

    logic [MW-1:0] n_nm, n_dm;

    // Stage zero: magnitudes and signs.
    always_comb begin
        n_nm = i_num[PW-1] ? (~{1'b1, i_num} + 1'b1) : {1'b0, i_num};
        n_dm = i_den[PW-1] ? (~{1'b1, i_den} + 1'b1) : {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_hit[0] <= i_hit;
        r_par[0] <= (i_den == '0);
        r_neg[0] <= i_num[PW-1] ^ i_den[PW-1];
        r_one[0] <= 1'b0;
        r_rem[0] <= n_nm;
        r_d[0]   <= n_dm;
        r_q[0]   <= '0;
        r_ax[0]  <= i_ax;
        r_ay[0]  <= i_ay;
        r_wx[0]  <= i_wx;
        r_wy[0]  <= i_wy;
    end

    // Divider stages. Step zero decides the integer part (0 or saturated 1);
    // later steps produce one fraction bit each.
    for (genvar g = 0; g < NS; g++) begin : g_div
        logic [MW:0]   n_sh;
        logic          n_ge;
        logic [MW-1:0] n_rem;
        logic          n_one;
        logic [QW-1:0] n_q;
        always_comb begin
            if (g == 0) begin
                // Any integer part of one or more saturates alpha at one.
                n_sh  = {1'b0, r_rem[g]};
                n_ge  = (r_rem[g] >= r_d[g]);
                n_rem = n_ge ? '0 : r_rem[g];
                n_one = n_ge;
                n_q   = r_q[g];
            end else begin
                n_sh  = {r_rem[g], 1'b0};
                n_ge  = (n_sh >= {1'b0, r_d[g]});
                n_rem = n_ge ? MW'(n_sh - {1'b0, r_d[g]}) : MW'(n_sh);
                n_one = r_one[g];
                n_q   = {r_q[g][QW-2:0], n_ge};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_hit[g+1] <= r_hit[g];
            r_par[g+1] <= r_par[g];
            r_neg[g+1] <= r_neg[g];
            r_one[g+1] <= n_one;
            r_rem[g+1] <= n_rem;
            r_d[g+1]   <= r_d[g];
            r_q[g+1]   <= n_q;
            r_ax[g+1]  <= r_ax[g];
            r_ay[g+1]  <= r_ay[g];
            r_wx[g+1]  <= r_wx[g];
            r_wy[g+1]  <= r_wy[g];
        end
    end

    // Alpha select: saturated one, quotient, or zero when parallel.
    logic [QW-1:0]        n_am;
    logic signed [AW-1:0] n_alpha;
    always_comb begin
        if (r_par[NS]) begin
            n_am = '0;
        end else if (r_one[NS]) begin
            n_am = QW'(1) << FRAC_BITS;
        end else begin
            n_am = r_q[NS];
        end
        n_alpha = r_neg[NS] ? -$signed({1'b0, n_am}) : $signed({1'b0, n_am});
    end

    // Product stage.
    logic                 r_pv, r_phit, r_ppar;
    logic signed [XW-1:0] r_mx, r_my;
    logic signed [COORD_BITS-1:0] r_pax, r_pay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= r_v[NS];
        end
        r_phit <= r_hit[NS];
        r_ppar <= r_par[NS];
        r_mx   <= XW'(n_alpha) * XW'(r_wx[NS]);
        r_my   <= XW'(n_alpha) * XW'(r_wy[NS]);
        r_pax  <= r_ax[NS];
        r_pay  <= r_ay[NS];
    end

    // Final subtract and output register.
    logic signed [FW-1:0] n_rx, n_ry;
    always_comb begin
        n_rx = (FW'(r_pax) <<< FRAC_BITS) - FW'(r_mx);
        n_ry = (FW'(r_pay) <<< FRAC_BITS) - FW'(r_my);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_pv;
        end
        o_hit      <= r_phit;
        o_parallel <= r_phit && r_ppar;
        o_px       <= r_phit ? sip_pkg::OUT_BITS'(n_rx) : '0;
        o_py       <= r_phit ? sip_pkg::OUT_BITS'(n_ry) : '0;
    end

    // Outputs carry nothing but zero on a miss.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> (o_px == '0) && (o_py == '0) && !o_parallel)
        else $error("miss result not zero");
    a_par_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_parallel |-> o_hit)
        else $error("parallel without hit");
    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |=> o_valid)
        else $error("result lost in last stage");

endmodule
`default_nettype wire
// ----------------------------------------------------------------------------

[design/segment_intersection_point.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection point
// Tests two closed segments AB and CD and gives their meeting point.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the eight coordinates and raise start; a transaction is taken at
//   each rising edge with start high and busy low. busy stays low, so
//   one transaction per cycle is taken.
//   Each transaction gives one result on o_hit, o_parallel, o_px, o_py,
//   marked by o_done for exactly one cycle. The receiver cannot stall.
//   Stages: 2 front stages, the queue register, FRAC_BITS+2 divider stages
//   (integer step plus one quotient bit per stage), 2 point stages.
//   The divider pipeline is the longest part; throughput is one
//   transaction per cycle.
//   px, py hold the point with FRAC_BITS fraction bits, zero on a miss.
//   Collinear touching pairs set o_parallel and give point A.
//   Synchronous reset empties all stages and the queue; no result follows.
// ----------------------------------------------------------------------------
module segment_intersection_point #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    output logic                              o_done,
    input  wire logic signed [COORD_BITS-1:0] i_ax,
    input  wire logic signed [COORD_BITS-1:0] i_ay,
    input  wire logic signed [COORD_BITS-1:0] i_bx,
    input  wire logic signed [COORD_BITS-1:0] i_by_coord,
    input  wire logic signed [COORD_BITS-1:0] i_cx,
    input  wire logic signed [COORD_BITS-1:0] i_cy,
    input  wire logic signed [COORD_BITS-1:0] i_dx,
    input  wire logic signed [COORD_BITS-1:0] i_dy,
    output logic                              o_hit,
    output logic                              o_parallel,
    output logic signed [sip_pkg::OUT_BITS-1:0] o_px,
    output logic signed [sip_pkg::OUT_BITS-1:0] o_py
);
    localparam int PW = 2 * COORD_BITS + 3;
    localparam int QD = 1 + 2 * PW + 2 * COORD_BITS + 2 * (COORD_BITS + 1);

    logic                         f_valid, f_hit;
    logic signed [PW-1:0]         f_num, f_den;
    logic signed [COORD_BITS-1:0] f_ax, f_ay;
    logic signed [COORD_BITS:0]   f_wx, f_wy;

    assign busy = 1'b0;

    // Front: differences, cross products and classification.
    sip_front #(.COORD_BITS(COORD_BITS), .PW(PW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start && !busy),
        .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx), .i_by(i_by_coord),
        .i_cx(i_cx), .i_cy(i_cy), .i_dx(i_dx), .i_dy(i_dy),
        .o_valid(f_valid), .o_hit(f_hit), .o_num(f_num), .o_den(f_den),
        .o_ax(f_ax), .o_ay(f_ay), .o_wx(f_wx), .o_wy(f_wy)
    );

    // Queue between front and back; the back drains every cycle.
    logic          q_empty;
    logic [QD-1:0] q_out;
    sip_queue #(.WIDTH(QD), .DEPTH(sip_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_valid),
        .i_data({f_hit, f_num, f_den, f_ax, f_ay, f_wx, f_wy}),
        .i_pop(1'b1), .o_empty(q_empty), .o_data(q_out)
    );

    logic                         b_hit;
    logic signed [PW-1:0]         b_num, b_den;
    logic signed [COORD_BITS-1:0] b_ax, b_ay;
    logic signed [COORD_BITS:0]   b_wx, b_wy;
    assign {b_hit, b_num, b_den, b_ax, b_ay, b_wx, b_wy} = q_out;

    // Back: alpha division and the point.
    sip_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .PW(PW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(!q_empty),
        .i_hit(b_hit), .i_num(b_num), .i_den(b_den),
        .i_ax(b_ax), .i_ay(b_ay), .i_wx(b_wx), .i_wy(b_wy),
        .o_valid(o_done), .o_hit(o_hit), .o_parallel(o_parallel),
        .o_px(o_px), .o_py(o_py)
    );

endmodule
`default_nettype wire
// ----------------------------------------------------------------------------

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Segment intersection point testbench
// Drives segment pairs in random bursts, predicts the hit flags and the
// fixed point meeting point of each pair, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CB        = sip_pkg::COORD_BITS_DEF;
    localparam int FB        = sip_pkg::FRAC_BITS_DEF;
    localparam int OB        = sip_pkg::OUT_BITS;
    localparam int LATENCY   = FB + 7;
    localparam int WATCHDOG  = 2000;
    localparam int N_RANDOM  = 1530;

    typedef struct packed {
        logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    } seg_pair_t;

    typedef struct packed {
        logic          hit;
        logic          parallel;
        logic [OB-1:0] px;
        logic [OB-1:0] py;
    } meet_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic o_done, o_hit, o_parallel;
    logic signed [OB-1:0] o_px, o_py;
    logic signed [CB-1:0] i_ax = '0, i_ay = '0, i_bx = '0, i_by_coord = '0;
    logic signed [CB-1:0] i_cx = '0, i_cy = '0, i_dx = '0, i_dy = '0;

    seg_pair_t pending_pairs[$];
    meet_t     expected_meets[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    bit        drain_hold = 1'b0;
    bit        stimulus_done = 1'b0;

    segment_intersection_point DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .o_done(o_done), .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx),
        .i_by_coord(i_by_coord), .i_cx(i_cx), .i_cy(i_cy), .i_dx(i_dx),
        .i_dy(i_dy), .o_hit(o_hit), .o_parallel(o_parallel),
        .o_px(o_px), .o_py(o_py)
    );

    always #5 i_clk = ~i_clk;

    // Twice the signed area of triangle (o, e, t).
    function automatic longint area_x2(longint ox, longint oy, longint ex,
                                       longint ey, longint tx, longint ty);
        return (ex - ox) * (ty - oy) - (ey - oy) * (tx - ox);
    endfunction

    function automatic int sgn(longint v);
        return (v > 0) - (v < 0);
    endfunction

    // Predicts the result of one segment pair.
    function automatic meet_t predict_meet(seg_pair_t p);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint vx, vy, wx, wy, num, den, alpha, rx, ry;
        longint unsigned n, d, ip, rem, q;
        meet_t r;
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
        cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
        r = '0;
        if (sgn(area_x2(cx, cy, dx, dy, ax, ay)) * sgn(area_x2(cx, cy, dx, dy, bx, by)) > 0 ||
            sgn(area_x2(ax, ay, bx, by, cx, cy)) * sgn(area_x2(ax, ay, bx, by, dx, dy)) > 0)
            return r;
        r.hit = 1'b1;
        vx = dx - cx; vy = dy - cy; wx = ax - bx; wy = ay - by;
        num = (cx - ax) * vy + (ay - cy) * vx;
        den = vx * wy - vy * wx;
        if (den == 0) begin
            r.parallel = 1'b1;
            alpha = 0;
        end else begin
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            ip = n / d;
            rem = n % d;
            q = 0;
            for (int i = 0; i < FB; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    q = q | 1;
                end
            end
            // The integer part saturates at one.
            alpha = (ip >= 1) ? (longint'(1) << FB) : longint'(q);
            if ((num < 0) != (den < 0)) alpha = -alpha;
        end
        rx = ax * (longint'(1) << FB) - alpha * wx;
        ry = ay * (longint'(1) << FB) - alpha * wy;
        r.px = rx[OB-1:0];
        r.py = ry[OB-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic signed [CB-1:0] rnd_coord(int span);
        return CB'($signed($urandom_range(2 * span)) - span);
    endfunction

    // Some pairs get a shared end point, a common line, a crossing or a point segment; the rest is random spread.
    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int span, kind;
        int pick;
        pick = $urandom_range(9);
        span = (pick < 3) ? 32767 : (pick < 7) ? 200 : 4;
        kind = $urandom_range(9);
        p.ax = rnd_coord(span); p.ay = rnd_coord(span);
        p.bx = rnd_coord(span); p.by = rnd_coord(span);
        p.cx = rnd_coord(span); p.cy = rnd_coord(span);
        p.dx = rnd_coord(span); p.dy = rnd_coord(span);
        if (kind == 0) begin
            p = {$urandom, $urandom, $urandom, $urandom};
        end else if (kind == 1) begin
            // Shared end point.
            p.cx = p.bx; p.cy = p.by;
        end else if (kind == 2) begin
            // Collinear pair along one axis, overlapping or not.
            p.ay = p.by; p.cy = p.by; p.dy = p.by;
        end else if (kind == 3) begin
            // Crossing pair through a common midpoint.
            p.cx = -p.ax; p.cy = p.bx; p.dx = p.ax; p.dy = -p.bx;
            p.ay = p.ax; p.by = -p.ax; p.bx = -p.ax;
        end else if (kind == 4) begin
            p.bx = p.ax; p.by = p.ay;
        end
        return p;
    endfunction

    function automatic seg_pair_t mk(int ax, int ay, int bx, int by,
                                     int cx, int cy, int dx, int dy);
        seg_pair_t p;
        p.ax = CB'(ax); p.ay = CB'(ay); p.bx = CB'(bx); p.by = CB'(by);
        p.cx = CB'(cx); p.cy = CB'(cy); p.dx = CB'(dx); p.dy = CB'(dy);
        return p;
    endfunction

    // Fill the item queue: directed corners first, then random pairs.
    initial begin
        pending_pairs.push_back(mk(0, 0, 10, 10, 0, 10, 10, 0));
        pending_pairs.push_back(mk(0, 0, 1, 0, 0, 1, 1, 1));
        pending_pairs.push_back(mk(0, 0, 10, 0, 10, 0, 10, 5));
        pending_pairs.push_back(mk(0, 0, 10, 0, 5, 0, 20, 0));
        pending_pairs.push_back(mk(0, 0, 10, 0, 11, 0, 20, 0));
        pending_pairs.push_back(mk(3, 3, 3, 3, 3, 3, 3, 3));
        pending_pairs.push_back(mk(3, 3, 3, 3, 0, 0, 6, 6));
        pending_pairs.push_back(mk(0, 0, 3, 7, 0, 1, 3, 0));
        pending_pairs.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        pending_pairs.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768));
        pending_pairs.push_back(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        pending_pairs.push_back(mk(32767, -32768, -32768, 32767, -1, -1, 32767, 32767));
        pending_pairs.push_back(mk(-1, -1, -1, -1, -1, -1, 0, 0));
        pending_pairs.push_back(mk(0, 0, 32767, 1, 32767, 0, 0, 1));
        pending_pairs.push_back(mk(5, 5, 6, 6, -5, 5, -6, 6));
        for (int i = 0; i < N_RANDOM; i++) pending_pairs.push_back(random_pair());
    end

    // Driver: bursts and gaps, with one pause until everything has drained.
    always @(posedge i_clk) begin
        seg_pair_t p;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && busy) begin
                // Hold the current item until it is taken.
            end else if (drain_hold) begin
                start <= 1'b0;
                if (expected_meets.size() == 0) drain_hold <= 1'b0;
            end else if (pending_pairs.size() == 0) begin
                start <= 1'b0;
                stimulus_done <= 1'b1;
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                p = pending_pairs.pop_front();
                expected_meets.push_back(predict_meet(p));
                i_ax <= p.ax; i_ay <= p.ay; i_bx <= p.bx; i_by_coord <= p.by;
                i_cx <= p.cx; i_cy <= p.cy; i_dx <= p.dx; i_dy <= p.dy;
                start <= 1'b1;
                if (pending_pairs.size() == 800) drain_hold <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(40);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        meet_t want;
        if (i_rst_n) begin
            if ((start && !busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_done) begin
                if (expected_meets.size() == 0) begin
                    $display("unexpected result at %0t", $time);
                    error_count++;
                end else begin
                    want = expected_meets.pop_front();
                    if (o_hit !== want.hit) report_mismatch("hit", o_hit, want.hit);
                    if (o_parallel !== want.parallel)
                        report_mismatch("parallel", o_parallel, want.parallel);
                    if (o_px !== want.px)
                        report_mismatch("px", o_px, $signed(want.px));
                    if (o_py !== want.py)
                        report_mismatch("py", o_py, $signed(want.py));
                end
            end
        end
    end

    // Reset, end of run and watchdog.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stimulus_done && expected_meets.size() == 0)
               && idle_cycles < WATCHDOG)
            @(posedge i_clk);
        if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
        end else begin
            repeat (LATENCY + 5) @(posedge i_clk);
            if (error_count == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
